### src/mqtt_pkg.sv
// Shared constants and types for the MQTT control packet parser.
// Holds parse phase codes, field tags, command codes and status codes.
// Depends on nothing.
package mqtt_pkg;

  localparam int MAX_LEN_BYTES = 4;

  localparam int PhaseW = 5;
  localparam int TagW   = 5;

  // Parse phases.
  localparam logic [PhaseW-1:0] PH_HDR     = 5'd0;
  localparam logic [PhaseW-1:0] PH_LEN     = 5'd1;
  localparam logic [PhaseW-1:0] PH_PN_HI   = 5'd2;
  localparam logic [PhaseW-1:0] PH_PN_LO   = 5'd3;
  localparam logic [PhaseW-1:0] PH_PN_STR  = 5'd4;
  localparam logic [PhaseW-1:0] PH_VER     = 5'd5;
  localparam logic [PhaseW-1:0] PH_FLG     = 5'd6;
  localparam logic [PhaseW-1:0] PH_KA_HI   = 5'd7;
  localparam logic [PhaseW-1:0] PH_KA_LO   = 5'd8;
  localparam logic [PhaseW-1:0] PH_CID_HI  = 5'd9;
  localparam logic [PhaseW-1:0] PH_CID_LO  = 5'd10;
  localparam logic [PhaseW-1:0] PH_CID_STR = 5'd11;
  localparam logic [PhaseW-1:0] PH_WT_HI   = 5'd12;
  localparam logic [PhaseW-1:0] PH_WT_LO   = 5'd13;
  localparam logic [PhaseW-1:0] PH_WT_STR  = 5'd14;
  localparam logic [PhaseW-1:0] PH_WM_HI   = 5'd15;
  localparam logic [PhaseW-1:0] PH_WM_LO   = 5'd16;
  localparam logic [PhaseW-1:0] PH_WM_STR  = 5'd17;
  localparam logic [PhaseW-1:0] PH_US_HI   = 5'd18;
  localparam logic [PhaseW-1:0] PH_US_LO   = 5'd19;
  localparam logic [PhaseW-1:0] PH_US_STR  = 5'd20;
  localparam logic [PhaseW-1:0] PH_PW_HI   = 5'd21;
  localparam logic [PhaseW-1:0] PH_PW_LO   = 5'd22;
  localparam logic [PhaseW-1:0] PH_PW_STR  = 5'd23;
  localparam logic [PhaseW-1:0] PH_MID_HI  = 5'd24;
  localparam logic [PhaseW-1:0] PH_MID_LO  = 5'd25;
  localparam logic [PhaseW-1:0] PH_TP_HI   = 5'd26;
  localparam logic [PhaseW-1:0] PH_TP_LO   = 5'd27;
  localparam logic [PhaseW-1:0] PH_TP_STR  = 5'd28;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 5'd29;
  localparam logic [PhaseW-1:0] PH_IGNORE  = 5'd30;

  // Field tags.
  localparam logic [TagW-1:0] TAG_HEADER     = 5'd0;
  localparam logic [TagW-1:0] TAG_LENGTH     = 5'd1;
  localparam logic [TagW-1:0] TAG_PN_LEN     = 5'd2;
  localparam logic [TagW-1:0] TAG_PN_TEXT    = 5'd3;
  localparam logic [TagW-1:0] TAG_VERSION    = 5'd4;
  localparam logic [TagW-1:0] TAG_FLAGS      = 5'd5;
  localparam logic [TagW-1:0] TAG_KEEPALIVE  = 5'd6;
  localparam logic [TagW-1:0] TAG_CID_LEN    = 5'd7;
  localparam logic [TagW-1:0] TAG_CID_TEXT   = 5'd8;
  localparam logic [TagW-1:0] TAG_WT_LEN     = 5'd9;
  localparam logic [TagW-1:0] TAG_WT_TEXT    = 5'd10;
  localparam logic [TagW-1:0] TAG_WM_LEN     = 5'd11;
  localparam logic [TagW-1:0] TAG_WM_TEXT    = 5'd12;
  localparam logic [TagW-1:0] TAG_US_LEN     = 5'd13;
  localparam logic [TagW-1:0] TAG_US_TEXT    = 5'd14;
  localparam logic [TagW-1:0] TAG_PW_LEN     = 5'd15;
  localparam logic [TagW-1:0] TAG_PW_TEXT    = 5'd16;
  localparam logic [TagW-1:0] TAG_MSGID      = 5'd17;
  localparam logic [TagW-1:0] TAG_CONNACK    = 5'd18;
  localparam logic [TagW-1:0] TAG_TP_LEN     = 5'd19;
  localparam logic [TagW-1:0] TAG_TP_TEXT    = 5'd20;
  localparam logic [TagW-1:0] TAG_PAYLOAD    = 5'd21;
  localparam logic [TagW-1:0] TAG_IGNORED    = 5'd22;

  // Command codes.
  localparam logic [3:0] T_CONNECT   = 4'd1;
  localparam logic [3:0] T_CONNACK   = 4'd2;
  localparam logic [3:0] T_PUBLISH   = 4'd3;
  localparam logic [3:0] T_FIRST_ID  = 4'd4;
  localparam logic [3:0] T_SUBSCRIBE = 4'd8;
  localparam logic [3:0] T_LAST_ID   = 4'd9;

  // CONNECT flag bits.
  localparam int FlagWillBit = 2;
  localparam int FlagPassBit = 6;
  localparam int FlagUserBit = 7;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LEN_LONG = 2'd1;
  localparam logic [1:0] ST_OVERRUN  = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  localparam logic [7:0] LenDataMask = 8'h7f;
  localparam logic [7:0] LenContMask = 8'h80;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              conn_end;
  } after_t;

  function automatic logic [TagW-1:0] tag_of_phase(input logic [PhaseW-1:0] ph);
    logic [TagW-1:0] t;
    case (ph)
      PH_HDR:                t = TAG_HEADER;
      PH_LEN:                t = TAG_LENGTH;
      PH_PN_HI, PH_PN_LO:    t = TAG_PN_LEN;
      PH_PN_STR:             t = TAG_PN_TEXT;
      PH_VER:                t = TAG_VERSION;
      PH_FLG:                t = TAG_FLAGS;
      PH_KA_HI, PH_KA_LO:    t = TAG_KEEPALIVE;
      PH_CID_HI, PH_CID_LO:  t = TAG_CID_LEN;
      PH_CID_STR:            t = TAG_CID_TEXT;
      PH_WT_HI, PH_WT_LO:    t = TAG_WT_LEN;
      PH_WT_STR:             t = TAG_WT_TEXT;
      PH_WM_HI, PH_WM_LO:    t = TAG_WM_LEN;
      PH_WM_STR:             t = TAG_WM_TEXT;
      PH_US_HI, PH_US_LO:    t = TAG_US_LEN;
      PH_US_STR:             t = TAG_US_TEXT;
      PH_PW_HI, PH_PW_LO:    t = TAG_PW_LEN;
      PH_PW_STR:             t = TAG_PW_TEXT;
      PH_MID_HI, PH_MID_LO:  t = TAG_MSGID;
      PH_TP_HI, PH_TP_LO:    t = TAG_TP_LEN;
      PH_TP_STR:             t = TAG_TP_TEXT;
      PH_PAYLOAD:            t = TAG_PAYLOAD;
      default:               t = TAG_IGNORED;
    endcase
    return t;
  endfunction

  function automatic logic is_hi_phase(input logic [PhaseW-1:0] ph);
    return ph == PH_PN_HI || ph == PH_CID_HI || ph == PH_WT_HI || ph == PH_WM_HI ||
           ph == PH_US_HI || ph == PH_PW_HI || ph == PH_TP_HI;
  endfunction

  function automatic logic is_lo_phase(input logic [PhaseW-1:0] ph);
    return ph == PH_PN_LO || ph == PH_CID_LO || ph == PH_WT_LO || ph == PH_WM_LO ||
           ph == PH_US_LO || ph == PH_PW_LO || ph == PH_TP_LO;
  endfunction

  function automatic logic is_str_phase(input logic [PhaseW-1:0] ph);
    return ph == PH_PN_STR || ph == PH_CID_STR || ph == PH_WT_STR || ph == PH_WM_STR ||
           ph == PH_US_STR || ph == PH_PW_STR || ph == PH_TP_STR;
  endfunction

  function automatic logic needs_body(input logic [3:0] t);
    return t == T_CONNECT || t == T_CONNACK || t == T_PUBLISH ||
           (t >= T_FIRST_ID && t <= T_LAST_ID);
  endfunction

  function automatic logic [PhaseW-1:0] first_body_phase(input logic [3:0] t);
    logic [PhaseW-1:0] p;
    if (t == T_CONNECT) begin
      p = PH_PN_HI;
    end else if (t == T_PUBLISH) begin
      p = PH_TP_HI;
    end else if (t == T_CONNACK || (t >= T_FIRST_ID && t <= T_LAST_ID)) begin
      p = PH_MID_HI;
    end else begin
      p = PH_IGNORE;
    end
    return p;
  endfunction

  // Phase that follows a completed string. conn_end marks the end of the
  // CONNECT field list, where leftover body bytes are a size mismatch.
  function automatic after_t after_string(input logic [PhaseW-1:0] str_ph,
                                          input logic [7:0] flags,
                                          input logic [1:0] qos);
    after_t r;
    r.phase    = PH_IGNORE;
    r.conn_end = 1'b0;
    case (str_ph)
      PH_PN_STR: r.phase = PH_VER;
      PH_CID_STR: begin
        if (flags[FlagWillBit]) begin
          r.phase = PH_WT_HI;
        end else if (flags[FlagUserBit]) begin
          r.phase = PH_US_HI;
        end else if (flags[FlagPassBit]) begin
          r.phase = PH_PW_HI;
        end else begin
          r.conn_end = 1'b1;
        end
      end
      PH_WT_STR: r.phase = PH_WM_HI;
      PH_WM_STR: begin
        if (flags[FlagUserBit]) begin
          r.phase = PH_US_HI;
        end else if (flags[FlagPassBit]) begin
          r.phase = PH_PW_HI;
        end else begin
          r.conn_end = 1'b1;
        end
      end
      PH_US_STR: begin
        if (flags[FlagPassBit]) begin
          r.phase = PH_PW_HI;
        end else begin
          r.conn_end = 1'b1;
        end
      end
      PH_PW_STR: r.conn_end = 1'b1;
      PH_TP_STR: r.phase = (qos != 2'd0) ? PH_MID_HI : PH_PAYLOAD;
      default:   r.phase = PH_IGNORE;
    endcase
    return r;
  endfunction

endpackage

### src/mqtt_packet_parser.sv
// MQTT 3.1.1 control packet parser, one stream byte per beat.
// Holds the whole parser: per-byte state update and the result register.
// Depends on mqtt_pkg.
//
// Each accepted byte comes back from the result register as one result beat carrying
// the byte, its role tag and the packet fields decoded so far. One byte is taken every
// cycle while data_stall is low; the parse state is updated in a single step per byte,
// and the result register lets the next byte in while a held result is taken.
// data_stall is high only while a result is held and result_stall is high. The remaining
// length is limited to MAX_LEN_BYTES length bytes; a longer one ends the packet
// with status 1 and the next byte is taken as a new fixed header.
module mqtt_packet_parser
  import mqtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  byte_out,
  output logic [4:0]  field_tag,
  output logic [3:0]  packet_type,
  output logic [1:0]  qos_level,
  output logic [27:0] remaining_length,
  output logic [15:0] packet_id,
  output logic [7:0]  connect_flag_bits,
  output logic [15:0] keep_alive,
  output logic [7:0]  connack_code,
  output logic        packet_done,
  output logic [1:0]  parse_status
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [3:0]        cur_type, cur_type_next;
  logic [1:0]        cur_qos, cur_qos_next;
  logic [27:0]       length_accum, length_accum_next;
  logic [2:0]        length_byte_count, length_byte_count_next;
  logic [27:0]       bytes_left, bytes_left_next;
  logic [15:0]       field_left, field_left_next;
  logic [7:0]        flags_reg, flags_reg_next;
  logic [15:0]       msgid_reg, msgid_reg_next;
  logic [15:0]       keepalive_reg, keepalive_reg_next;
  logic [7:0]        connack_reg, connack_reg_next;
  logic [1:0]        error_code, error_code_next;

  logic              accept;
  logic [TagW-1:0]   tag;
  logic              done;
  logic [1:0]        status;
  logic [PhaseW-1:0] nx;
  logic [27:0]       bl_dec;
  logic [15:0]       fl_lo;
  logic [15:0]       fl_dec;
  logic [PhaseW-1:0] str_ph;
  after_t            after;
  logic [4:0]        len_shift;
  logic [27:0]       len_add;

  assign data_stall = result_valid & result_stall;
  assign accept     = data_valid & ~data_stall;

  always_comb begin
    phase_next             = phase;
    cur_type_next          = cur_type;
    cur_qos_next           = cur_qos;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    bytes_left_next        = bytes_left;
    field_left_next        = field_left;
    flags_reg_next         = flags_reg;
    msgid_reg_next         = msgid_reg;
    keepalive_reg_next     = keepalive_reg;
    connack_reg_next       = connack_reg;
    error_code_next        = error_code;
    tag                    = tag_of_phase(phase);
    done                   = 1'b0;
    status                 = ST_OK;
    nx                     = PH_IGNORE;

    bl_dec    = (bytes_left != 28'd0) ? bytes_left - 28'd1 : bytes_left;
    fl_lo     = field_left | {8'd0, data_byte};
    fl_dec    = field_left - 16'd1;
    str_ph    = is_lo_phase(phase) ? phase + 5'd1 : phase;
    after     = after_string(str_ph, flags_reg, cur_qos);
    len_shift = 5'(length_byte_count[1:0]) * 5'd7;
    len_add   = {20'd0, data_byte & LenDataMask} << len_shift;

    if (phase == PH_HDR) begin
      cur_type_next          = data_byte[7:4];
      cur_qos_next           = data_byte[2:1];
      length_accum_next      = '0;
      length_byte_count_next = '0;
      bytes_left_next        = '0;
      field_left_next        = '0;
      flags_reg_next         = '0;
      msgid_reg_next         = '0;
      keepalive_reg_next     = '0;
      connack_reg_next       = '0;
      error_code_next        = ST_OK;
      phase_next             = PH_LEN;
    end else if (phase == PH_LEN) begin
      length_accum_next      = length_accum + len_add;
      length_byte_count_next = length_byte_count + 3'd1;
      if ((data_byte & LenContMask) != 8'd0) begin
        if (length_byte_count_next >= 3'(MAX_LEN_BYTES)) begin
          done       = 1'b1;
          status     = ST_LEN_LONG;
          phase_next = PH_HDR;
        end
      end else begin
        bytes_left_next = length_accum_next;
        if (length_accum_next == 28'd0) begin
          done       = 1'b1;
          status     = needs_body(cur_type) ? ST_OVERRUN : ST_OK;
          phase_next = PH_HDR;
        end else begin
          phase_next = first_body_phase(cur_type);
        end
      end
    end else begin
      bytes_left_next = bl_dec;
      if (is_hi_phase(phase)) begin
        field_left_next = {data_byte, 8'd0};
        nx              = phase + 5'd1;
      end else if (is_lo_phase(phase)) begin
        field_left_next = fl_lo;
        if ({12'd0, fl_lo} > bl_dec) begin
          if (error_code == ST_OK) begin
            error_code_next = ST_OVERRUN;
          end
          nx = PH_IGNORE;
        end else if (fl_lo == 16'd0) begin
          nx = after.phase;
          if (after.conn_end && bl_dec != 28'd0 && error_code == ST_OK) begin
            error_code_next = ST_MISMATCH;
          end
        end else begin
          nx = phase + 5'd1;
        end
      end else if (is_str_phase(phase)) begin
        field_left_next = fl_dec;
        if (fl_dec == 16'd0) begin
          nx = after.phase;
          if (after.conn_end && bl_dec != 28'd0 && error_code == ST_OK) begin
            error_code_next = ST_MISMATCH;
          end
        end else begin
          nx = phase;
        end
      end else if (phase == PH_VER) begin
        nx = PH_FLG;
      end else if (phase == PH_FLG) begin
        flags_reg_next = data_byte;
        nx             = PH_KA_HI;
      end else if (phase == PH_KA_HI) begin
        keepalive_reg_next = {data_byte, 8'd0};
        nx                 = PH_KA_LO;
      end else if (phase == PH_KA_LO) begin
        keepalive_reg_next = keepalive_reg | {8'd0, data_byte};
        nx                 = PH_CID_HI;
      end else if (phase == PH_MID_HI) begin
        if (cur_type == T_CONNACK) begin
          tag = TAG_CONNACK;
        end else begin
          msgid_reg_next = {data_byte, 8'd0};
        end
        nx = PH_MID_LO;
      end else if (phase == PH_MID_LO) begin
        if (cur_type == T_CONNACK) begin
          tag              = TAG_CONNACK;
          connack_reg_next = data_byte;
          nx               = PH_IGNORE;
        end else begin
          msgid_reg_next = msgid_reg | {8'd0, data_byte};
          nx = (cur_type == T_PUBLISH || cur_type == T_SUBSCRIBE) ? PH_PAYLOAD : PH_IGNORE;
        end
      end else if (phase == PH_PAYLOAD) begin
        nx = PH_PAYLOAD;
      end else begin
        nx = PH_IGNORE;
      end

      phase_next = nx;
      if (bl_dec == 28'd0) begin
        done = 1'b1;
        if (error_code_next != ST_OK) begin
          status = error_code_next;
        end else begin
          status = (nx == PH_PAYLOAD || nx == PH_IGNORE) ? ST_OK : ST_OVERRUN;
        end
        phase_next = PH_HDR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR;
      cur_type          <= '0;
      cur_qos           <= '0;
      length_accum      <= '0;
      length_byte_count <= '0;
      bytes_left        <= '0;
      field_left        <= '0;
      flags_reg         <= '0;
      msgid_reg         <= '0;
      keepalive_reg     <= '0;
      connack_reg       <= '0;
      error_code        <= ST_OK;
    end else if (accept) begin
      phase             <= phase_next;
      cur_type          <= cur_type_next;
      cur_qos           <= cur_qos_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      bytes_left        <= bytes_left_next;
      field_left        <= field_left_next;
      flags_reg         <= flags_reg_next;
      msgid_reg         <= msgid_reg_next;
      keepalive_reg     <= keepalive_reg_next;
      connack_reg       <= connack_reg_next;
      error_code        <= error_code_next;
    end
  end

  // The result register holds a beat until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept | data_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_out          <= data_byte;
      field_tag         <= tag;
      packet_type       <= cur_type_next;
      qos_level         <= cur_qos_next;
      remaining_length  <= length_accum_next;
      packet_id         <= msgid_reg_next;
      connect_flag_bits <= flags_reg_next;
      keep_alive        <= keepalive_reg_next;
      connack_code      <= connack_reg_next;
      packet_done       <= done;
      parse_status      <= status;
    end
  end

  a_status_only_when_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !packet_done) |-> parse_status == ST_OK)
    else $error("nonzero status on a beat that does not end a packet");

  a_done_restarts_header: assert property (@(posedge clk) disable iff (rst)
    (accept && done) |=> phase == PH_HDR)
    else $error("parser did not return to the header after a packet end");

  a_len_count_bound: assert property (@(posedge clk) disable iff (rst)
    length_byte_count <= 3'(MAX_LEN_BYTES))
    else $error("length byte count ran past its limit");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> result_valid)
    else $error("input stalled with no result held");

  a_tag_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> field_tag <= TAG_IGNORED)
    else $error("field tag out of range");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the MQTT control packet parser: directed packets, then random streams.
// Each accepted byte is decoded by a local model and every result beat is compared field by field.
// Depends on mqtt_pkg and mqtt_packet_parser.
module tb;
  import mqtt_pkg::*;

  typedef logic [7:0] bytes_t[$];

  typedef struct packed {
    logic [7:0]  b;
    logic [4:0]  tag;
    logic [3:0]  ptype;
    logic [1:0]  qos;
    logic [27:0] rlen;
    logic [15:0] mid;
    logic [7:0]  flags;
    logic [15:0] ka;
    logic [7:0]  cack;
    logic        done;
    logic [1:0]  status;
  } parsed_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  byte_out;
  logic [4:0]  field_tag;
  logic [3:0]  packet_type;
  logic [1:0]  qos_level;
  logic [27:0] remaining_length;
  logic [15:0] packet_id;
  logic [7:0]  connect_flag_bits;
  logic [15:0] keep_alive;
  logic [7:0]  connack_code;
  logic        packet_done;
  logic [1:0]  parse_status;

  mqtt_packet_parser DUT (
    .clk               (clk),
    .rst               (rst),
    .data_valid        (data_valid),
    .data_stall        (data_stall),
    .data_byte         (data_byte),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .byte_out          (byte_out),
    .field_tag         (field_tag),
    .packet_type       (packet_type),
    .qos_level         (qos_level),
    .remaining_length  (remaining_length),
    .packet_id         (packet_id),
    .connect_flag_bits (connect_flag_bits),
    .keep_alive        (keep_alive),
    .connack_code      (connack_code),
    .packet_done       (packet_done),
    .parse_status      (parse_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser state as the model tracks it.
  logic [PhaseW-1:0] st_phase = PH_HDR;
  logic [3:0]        st_type = 4'd0;
  logic [1:0]        st_qos = 2'd0;
  logic [27:0]       st_length = 28'd0;
  logic [2:0]        st_len_cnt = 3'd0;
  logic [27:0]       st_left = 28'd0;
  logic [15:0]       st_field = 16'd0;
  logic [7:0]        st_flags = 8'd0;
  logic [15:0]       st_msgid = 16'd0;
  logic [15:0]       st_keepalive = 16'd0;
  logic [7:0]        st_connack = 8'd0;
  logic [1:0]        st_err = ST_OK;

  parsed_byte_t decoded_bytes[$];
  logic [7:0]   body[$];
  int           mismatches = 0;
  int           bytes_sent = 0;
  bit           no_gaps = 1'b0;

  function automatic logic [TagW-1:0] role_tag(input logic [PhaseW-1:0] ph);
    case (ph)
      PH_HDR:                                 return TAG_HEADER;
      PH_LEN:                                 return TAG_LENGTH;
      PH_PN_HI, PH_PN_LO:                     return TAG_PN_LEN;
      PH_PN_STR:                              return TAG_PN_TEXT;
      PH_VER:                                 return TAG_VERSION;
      PH_FLG:                                 return TAG_FLAGS;
      PH_KA_HI, PH_KA_LO:                     return TAG_KEEPALIVE;
      PH_CID_HI, PH_CID_LO:                   return TAG_CID_LEN;
      PH_CID_STR:                             return TAG_CID_TEXT;
      PH_WT_HI, PH_WT_LO:                     return TAG_WT_LEN;
      PH_WT_STR:                              return TAG_WT_TEXT;
      PH_WM_HI, PH_WM_LO:                     return TAG_WM_LEN;
      PH_WM_STR:                              return TAG_WM_TEXT;
      PH_US_HI, PH_US_LO:                     return TAG_US_LEN;
      PH_US_STR:                              return TAG_US_TEXT;
      PH_PW_HI, PH_PW_LO:                     return TAG_PW_LEN;
      PH_PW_STR:                              return TAG_PW_TEXT;
      PH_MID_HI, PH_MID_LO:                   return TAG_MSGID;
      PH_TP_HI, PH_TP_LO:                     return TAG_TP_LEN;
      PH_TP_STR:                              return TAG_TP_TEXT;
      PH_PAYLOAD:                             return TAG_PAYLOAD;
      default:                                return TAG_IGNORED;
    endcase
  endfunction

  function automatic bit is_length_high(input logic [PhaseW-1:0] ph);
    case (ph)
      PH_PN_HI, PH_CID_HI, PH_WT_HI, PH_WM_HI, PH_US_HI, PH_PW_HI, PH_TP_HI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_text(input logic [PhaseW-1:0] ph);
    case (ph)
      PH_PN_STR, PH_CID_STR, PH_WT_STR, PH_WM_STR, PH_US_STR, PH_PW_STR, PH_TP_STR:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Body bytes still left once the CONNECT field list is complete are a size mismatch.
  function automatic logic [PhaseW-1:0] close_connect();
    if (st_left != 0 && st_err == ST_OK) st_err = ST_MISMATCH;
    return PH_IGNORE;
  endfunction

  function automatic logic [PhaseW-1:0] after_will_fields();
    if (st_flags[FlagUserBit]) return PH_US_HI;
    if (st_flags[FlagPassBit]) return PH_PW_HI;
    return close_connect();
  endfunction

  function automatic logic [PhaseW-1:0] text_next(input logic [PhaseW-1:0] ph);
    case (ph)
      PH_PN_STR:  return PH_VER;
      PH_CID_STR: return st_flags[FlagWillBit] ? PH_WT_HI : after_will_fields();
      PH_WT_STR:  return PH_WM_HI;
      PH_WM_STR:  return after_will_fields();
      PH_US_STR:  return st_flags[FlagPassBit] ? PH_PW_HI : close_connect();
      PH_PW_STR:  return close_connect();
      PH_TP_STR:  return (st_qos != 2'd0) ? PH_MID_HI : PH_PAYLOAD;
      default:    return PH_IGNORE;
    endcase
  endfunction

  function automatic parsed_byte_t decode_byte(input logic [7:0] b);
    parsed_byte_t      r;
    logic [PhaseW-1:0] ph;
    logic [PhaseW-1:0] nx;
    logic [TagW-1:0]   tag;
    logic              done;
    logic [1:0]        status;
    logic [31:0]       sum;
    ph = st_phase;
    tag = role_tag(ph);
    done = 1'b0;
    status = ST_OK;
    nx = PH_IGNORE;
    if (ph == PH_HDR) begin
      st_type = b[7:4];
      st_qos = b[2:1];
      st_length = 28'd0;
      st_len_cnt = 3'd0;
      st_left = 28'd0;
      st_field = 16'd0;
      st_flags = 8'd0;
      st_msgid = 16'd0;
      st_keepalive = 16'd0;
      st_connack = 8'd0;
      st_err = ST_OK;
      st_phase = PH_LEN;
    end else if (ph == PH_LEN) begin
      sum = 32'(st_length) + (32'(b & LenDataMask) << (7 * st_len_cnt[1:0]));
      st_length = sum[27:0];
      st_len_cnt = st_len_cnt + 3'd1;
      if ((b & LenContMask) != 8'h00) begin
        if (st_len_cnt >= MAX_LEN_BYTES) begin
          done = 1'b1;
          status = ST_LEN_LONG;
          st_phase = PH_HDR;
        end
      end else begin
        st_left = st_length;
        if (st_left == 0) begin
          done = 1'b1;
          // Every command from CONNECT up to SUBACK carries fields, so an empty body is short.
          status = (st_type >= T_CONNECT && st_type <= T_LAST_ID) ? ST_OVERRUN : ST_OK;
          st_phase = PH_HDR;
        end else if (st_type == T_CONNECT) begin
          st_phase = PH_PN_HI;
        end else if (st_type == T_PUBLISH) begin
          st_phase = PH_TP_HI;
        end else if (st_type >= T_CONNACK && st_type <= T_LAST_ID) begin
          st_phase = PH_MID_HI;
        end else begin
          st_phase = PH_IGNORE;
        end
      end
    end else begin
      if (st_left != 0) st_left = st_left - 28'd1;
      if (is_length_high(ph)) begin
        st_field = {b, 8'h00};
        nx = ph + 5'd1;
      end else if (is_length_high(ph - 5'd1)) begin
        st_field = st_field | {8'h00, b};
        if (28'(st_field) > st_left) begin
          if (st_err == ST_OK) st_err = ST_OVERRUN;
          nx = PH_IGNORE;
        end else if (st_field == 16'd0) begin
          nx = text_next(ph + 5'd1);
        end else begin
          nx = ph + 5'd1;
        end
      end else if (is_text(ph)) begin
        st_field = st_field - 16'd1;
        nx = (st_field == 16'd0) ? text_next(ph) : ph;
      end else begin
        case (ph)
          PH_VER: nx = PH_FLG;
          PH_FLG: begin
            st_flags = b;
            nx = PH_KA_HI;
          end
          PH_KA_HI: begin
            st_keepalive = {b, 8'h00};
            nx = PH_KA_LO;
          end
          PH_KA_LO: begin
            st_keepalive = st_keepalive | {8'h00, b};
            nx = PH_CID_HI;
          end
          PH_MID_HI: begin
            // CONNACK reuses the two id slots; its ack flags byte is not stored.
            if (st_type == T_CONNACK) begin
              tag = TAG_CONNACK;
            end else begin
              st_msgid = {b, 8'h00};
            end
            nx = PH_MID_LO;
          end
          PH_MID_LO: begin
            if (st_type == T_CONNACK) begin
              tag = TAG_CONNACK;
              st_connack = b;
              nx = PH_IGNORE;
            end else begin
              st_msgid = st_msgid | {8'h00, b};
              nx = (st_type == T_PUBLISH || st_type == T_SUBSCRIBE) ? PH_PAYLOAD : PH_IGNORE;
            end
          end
          PH_PAYLOAD: nx = PH_PAYLOAD;
          default:    nx = PH_IGNORE;
        endcase
      end
      st_phase = nx;
      if (st_left == 0) begin
        done = 1'b1;
        if (st_err != ST_OK) begin
          status = st_err;
        end else begin
          status = (nx == PH_PAYLOAD || nx == PH_IGNORE) ? ST_OK : ST_OVERRUN;
        end
        st_phase = PH_HDR;
      end
    end
    r.b = b;
    r.tag = tag;
    r.ptype = st_type;
    r.qos = st_qos;
    r.rlen = st_length;
    r.mid = st_msgid;
    r.flags = st_flags;
    r.ka = st_keepalive;
    r.cack = st_connack;
    r.done = done;
    r.status = status;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    end
  endtask

  // Result side: random stall, and a check of every beat that is taken.
  always @(posedge clk) begin
    result_stall <= !no_gaps && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin : result_check
    parsed_byte_t want;
    if (!rst && result_valid && !result_stall) begin
      if (decoded_bytes.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat 0x%0h arrived with nothing outstanding", $time, byte_out);
      end else begin
        want = decoded_bytes.pop_front();
        check_field("byte_out", want.b, byte_out);
        check_field("field_tag", want.tag, field_tag);
        check_field("packet_type", want.ptype, packet_type);
        check_field("qos_level", want.qos, qos_level);
        check_field("remaining_length", want.rlen, remaining_length);
        check_field("packet_id", want.mid, packet_id);
        check_field("connect_flag_bits", want.flags, connect_flag_bits);
        check_field("keep_alive", want.ka, keep_alive);
        check_field("connack_code", want.cack, connack_code);
        check_field("packet_done", want.done, packet_done);
        check_field("parse_status", want.status, parse_status);
      end
    end
  end

  // The byte is decoded once the beat is taken, in this process, so the model never races it.
  task automatic send_byte(input logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 6) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    decoded_bytes.push_back(decode_byte(b));
    bytes_sent++;
  endtask

  task automatic send_seq(input bytes_t s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  function automatic int rand_len();
    if ($urandom_range(149) == 0) return $urandom_range(300, 130);
    return $urandom_range(6);
  endfunction

  task automatic add_string(input int len);
    body.push_back(8'(len >> 8));
    body.push_back(8'(len));
    repeat (len) body.push_back(8'($urandom_range(255)));
  endtask

  // Header, remaining length (optionally padded with zero groups), then the body.
  task automatic send_packet(input logic [7:0] hdr, input int slack, input bit pad);
    int         declared;
    int         extra;
    logic [7:0] lenb[$];
    declared = body.size() + slack;
    if (declared < 0) declared = 0;
    do begin
      lenb.push_back(8'(declared & 'h7f) | ((declared > 'h7f) ? LenContMask : 8'h00));
      declared = declared >> 7;
    end while (declared != 0);
    if (pad && lenb.size() < MAX_LEN_BYTES) begin
      extra = $urandom_range(MAX_LEN_BYTES - lenb.size(), 1);
      lenb[lenb.size() - 1] = lenb[lenb.size() - 1] | LenContMask;
      repeat (extra - 1) lenb.push_back(LenContMask);
      lenb.push_back(8'h00);
    end
    send_byte(hdr);
    foreach (lenb[i]) send_byte(lenb[i]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Feeds filler until the parser looks for a fixed header again. Length bytes get the
  // continuation bit, which ends in the overlong case.
  task automatic realign();
    while (st_phase != PH_HDR) begin
      if (st_phase == PH_LEN) begin
        send_byte(8'($urandom_range(255)) | LenContMask);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Raw bytes. Only a single length byte may complete a length, which keeps bodies short.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(4, 1)) begin
      b = 8'($urandom_range(255));
      if (st_phase == PH_LEN && st_len_cnt != 3'd0) b = b | LenContMask;
      send_byte(b);
    end
  endtask

  task automatic send_random_packet();
    int         pick;
    int         slack;
    int         cut;
    int         kind;
    logic [7:0] hdr;
    logic [7:0] flags;
    logic [3:0] cmd;
    realign();
    body.delete();
    pick = $urandom_range(99);
    hdr = 8'($urandom_range(255));
    if (pick < 30) begin
      hdr[7:4] = T_CONNECT;
      add_string(($urandom_range(3) == 0) ? $urandom_range(6) : 4);
      body.push_back(8'($urandom_range(255)));
      flags = 8'($urandom_range(255));
      body.push_back(flags);
      body.push_back(8'($urandom_range(255)));
      body.push_back(8'($urandom_range(255)));
      add_string(rand_len());
      if (flags[FlagWillBit]) begin
        add_string(rand_len());
        add_string(rand_len());
      end
      if (flags[FlagUserBit]) add_string(rand_len());
      if (flags[FlagPassBit]) add_string(rand_len());
    end else if (pick < 60) begin
      hdr[7:4] = T_PUBLISH;
      add_string(rand_len());
      if (hdr[2:1] != 2'd0) begin
        body.push_back(8'($urandom_range(255)));
        body.push_back(8'($urandom_range(255)));
      end
      repeat (rand_len()) body.push_back(8'($urandom_range(255)));
    end else if (pick < 68) begin
      hdr[7:4] = T_CONNACK;
      body.push_back(8'($urandom_range(255)));
      body.push_back(8'($urandom_range(255)));
      if ($urandom_range(3) == 0) body.push_back(8'($urandom_range(255)));
    end else if (pick < 88) begin
      cmd = 4'($urandom_range(T_LAST_ID, T_FIRST_ID));
      hdr[7:4] = cmd;
      body.push_back(8'($urandom_range(255)));
      body.push_back(8'($urandom_range(255)));
      if (cmd == T_SUBSCRIBE || cmd == T_LAST_ID) begin
        repeat ($urandom_range(4)) body.push_back(8'($urandom_range(255)));
      end
    end else begin
      kind = $urandom_range(6);
      hdr[7:4] = (kind == 0) ? 4'd0 : 4'(kind + 9);
      repeat ($urandom_range(4)) body.push_back(8'($urandom_range(255)));
    end
    slack = 0;
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: slack = $urandom_range(3, 1);
        1: begin
          // Truncated: the packet ends before its fields do.
          cut = $urandom_range(body.size());
          while (body.size() > cut) void'(body.pop_back());
        end
        2: repeat ($urandom_range(3, 1)) body.push_back(8'($urandom_range(255)));
        default: begin
          if (body.size() != 0) body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
        end
      endcase
    end
    send_packet(hdr, slack, $urandom_range(7) == 0);
  endtask

  task automatic test_length_limits();
    // Continuation on the fourth length byte, then a padded four-byte length on an
    // unhandled command, then an empty unhandled packet.
    send_seq('{8'h1F, 8'h80, 8'h80, 8'h80, 8'h80});
    send_seq('{8'hF0, 8'h81, 8'h80, 8'h80, 8'h00, 8'hAA});
    send_seq('{8'hC0, 8'h00});
  endtask

  task automatic test_empty_bodies();
    send_seq('{8'h10, 8'h00});
  endtask

  task automatic test_acks();
    send_seq('{8'h20, 8'h03, 8'h01, 8'h05, 8'h77});
    send_seq('{8'h90, 8'h03, 8'h00, 8'h01, 8'h80});
  endtask

  task automatic test_field_overruns();
    send_seq('{8'h30, 8'h02, 8'hFF, 8'hFF});
    send_seq('{8'h40, 8'h01, 8'h00});
  endtask

  task automatic test_connect_trailing();
    send_seq('{8'h10, 8'h09, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h00, 8'hEE});
  endtask

  task automatic test_random_stream();
    int pick;
    while (bytes_sent < 1150) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_noise();
      end else if (pick < 10) begin
        realign();
        send_byte(8'($urandom_range(255)));
        repeat (MAX_LEN_BYTES) send_byte(8'($urandom_range(255)) | LenContMask);
      end else if (pick < 13) begin
        realign();
        send_byte(8'($urandom_range(255)));
        send_byte(8'h00);
      end else begin
        send_random_packet();
      end
    end
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    while (bytes_sent < 1400) send_random_packet();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_length_limits();
    test_empty_bodies();
    test_acks();
    test_field_overruns();
    test_connect_trailing();
    test_random_stream();
    test_back_to_back();
    data_valid <= 1'b0;
    while (decoded_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("mqtt_packet_parser: match");
    end else begin
      $display("mqtt_packet_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("mqtt_packet_parser: mismatch");
    $finish;
  end

endmodule
